FILE: sv/assert_macros.svh
// assert_macros.svh: assertion macros used by the checker file skset_checker.sv
// depends on nothing; each macro takes clock and active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define SKS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// implication from one cycle to the next
`define SKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `SKS_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

FILE: sv/skset_pkg.sv
// skset_pkg: command codes and the control structs of the sorted key set
// used by skset_cell and sorted_key_set; depends on nothing
package skset_pkg;

    localparam logic [1:0] CMD_SEARCH = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;

    localparam int unsigned COUNT_OUT_BITS = 7;

    // what a cell shows its neighbors besides its key
    typedef struct packed {
        logic occ;  // slot holds a key
        logic lt;   // held key is below the request key
    } t_link;

    // update applied to the whole chain in the execute cycle
    typedef struct packed {
        logic ins;
        logic del;
    } t_op;

endpackage

FILE: sv/skset_cell.sv
// skset_cell: one slot of the sorted chain, key register plus compare flags
// depends on skset_pkg; shifts with its neighbors on insert and delete
module skset_cell #(
    parameter int KEY_BITS = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmp,
    input  logic signed [KEY_BITS-1:0] i_cmp_key,
    input  skset_pkg::t_op             i_op,
    input  logic signed [KEY_BITS-1:0] i_op_key,
    input  logic signed [KEY_BITS-1:0] i_prev_key,
    input  skset_pkg::t_link           i_prev,
    input  logic signed [KEY_BITS-1:0] i_next_key,
    input  skset_pkg::t_link           i_next,
    output logic signed [KEY_BITS-1:0] o_key,
    output skset_pkg::t_link           o_link,
    output logic                       o_eq
);
    import skset_pkg::*;

    logic signed [KEY_BITS-1:0] r_key, n_key;
    logic                       r_occ, n_occ;
    logic                       r_lt, n_lt;
    logic                       r_eq, n_eq;

    always_comb begin
        n_key = r_key;
        n_occ = r_occ;
        n_lt  = r_lt;
        n_eq  = r_eq;
        if (i_cmp) begin
            n_lt = r_occ && (r_key < i_cmp_key);
            n_eq = r_occ && (r_key == i_cmp_key);
        end else if (i_op.ins && !r_lt) begin
            // first slot not below the key takes it, the rest move up
            n_key = i_prev.lt ? i_op_key : i_prev_key;
            n_occ = r_occ | i_prev.occ;
        end else if (i_op.del && !r_lt) begin
            n_key = i_next_key;
            n_occ = i_next.occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_lt  <= 1'b0;
            r_eq  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_lt  <= n_lt;
            r_eq  <= n_eq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    assign o_key  = r_key;
    assign o_link = '{occ: r_occ, lt: r_lt};
    assign o_eq   = r_eq;

endmodule

FILE: sv/sorted_key_set.sv
// sorted_key_set: set of distinct signed keys kept in ascending order
// depends on skset_pkg and skset_cell (one cell per slot)
//
//  channel   handshake          payload
//  request   start / busy       i_cmd, i_item_key
//  result    o_done strobe      o_hit, o_store_full, o_entry_count
//
// a request runs in order: the accept edge loads every cell's compare flags,
// then the registered busy applies the shift across the chain and registers the result
// o_done is high in the cycle after busy; busy is high for one cycle per request
// a new request may be accepted while the result strobe is shown
// synchronous reset empties the store at once, no clearing pass
// the receiver cannot stall, results are never held
module sorted_key_set #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic [31:0] i_item_key,
    output logic        o_done,
    output logic        o_hit,
    output logic        o_store_full,
    output logic [6:0]  o_entry_count
);
    import skset_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic                       w_accept;
    logic signed [KEY_BITS-1:0] w_in_key;
    logic signed [KEY_BITS-1:0] r_key;
    logic [1:0]                 r_cmd;
    logic                       r_busy;
    logic                       r_done;
    logic                       r_hit;
    logic                       r_full;
    logic [CW-1:0]              r_count, n_count;

    logic signed [KEY_BITS-1:0] w_key [CAPACITY];
    t_link                      w_link [CAPACITY];
    logic [CAPACITY-1:0]        w_eq;
    logic                       w_present;
    logic                       w_is_full;
    t_op                        w_op;

    assign w_accept  = start && !r_busy;
    assign w_in_key  = KEY_BITS'($signed(i_item_key));
    assign w_present = |w_eq;
    assign w_is_full = (r_count >= CW'(CAPACITY));

    always_comb begin
        w_op.ins = r_busy && (r_cmd == CMD_INSERT) && !w_present && !w_is_full;
        w_op.del = r_busy && (r_cmd == CMD_DELETE) && w_present;
        n_count  = r_count;
        if (w_op.ins) begin
            n_count = r_count + CW'(1);
        end else if (w_op.del) begin
            n_count = r_count - CW'(1);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [KEY_BITS-1:0] w_prev_key, w_next_key;
        t_link                      w_prev, w_next;

        if (i == 0) begin : g_first
            // left edge looks like an occupied slot below every key
            assign w_prev_key = '0;
            assign w_prev     = '{occ: 1'b1, lt: 1'b1};
        end else begin : g_mid_l
            assign w_prev_key = w_key[i-1];
            assign w_prev     = w_link[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_next_key = '0;
            assign w_next     = '{occ: 1'b0, lt: 1'b0};
        end else begin : g_mid_r
            assign w_next_key = w_key[i+1];
            assign w_next     = w_link[i+1];
        end

        skset_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmp      (w_accept),
            .i_cmp_key  (w_in_key),
            .i_op       (w_op),
            .i_op_key   (r_key),
            .i_prev_key (w_prev_key),
            .i_prev     (w_prev),
            .i_next_key (w_next_key),
            .i_next     (w_next),
            .o_key      (w_key[i]),
            .o_link     (w_link[i]),
            .o_eq       (w_eq[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= w_accept;
            r_done  <= r_busy;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= w_in_key;
            r_cmd <= i_cmd;
        end
        if (r_busy) begin
            r_hit  <= ((r_cmd == CMD_SEARCH) && w_present) || w_op.ins || w_op.del;
            r_full <= (r_cmd == CMD_INSERT) && !w_present && w_is_full;
        end
    end

    assign busy          = r_busy;
    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_store_full  = r_full;
    assign o_entry_count = COUNT_OUT_BITS'(r_count);

endmodule

FILE: sv/skset_checker.sv
// skset_checker: port-level assertions for sorted_key_set, bound to the top
// depends on assert_macros.svh
`include "assert_macros.svh"

module skset_checker #(
    parameter int CAPACITY = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic        o_hit,
    input logic        o_store_full,
    input logic [6:0]  o_entry_count
);

    `SKS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "request not taken")
    `SKS_ASSERT_NEXT(a_busy_done, i_clk, i_rst_n, busy, o_done && !busy, "result not strobed")
    `SKS_ASSERT(a_done_cause, i_clk, i_rst_n, o_done |-> $past(busy), "stray result strobe")
    `SKS_ASSERT(a_full_nohit, i_clk, i_rst_n, o_store_full |-> !o_hit, "full with hit")
    `SKS_ASSERT(a_count_cap, i_clk, i_rst_n,
        o_done |-> (32'(o_entry_count) <= 32'(CAPACITY)) || (CAPACITY > 127),
        "count above capacity")

endmodule

bind sorted_key_set skset_checker #(.CAPACITY(CAPACITY)) u_skset_checker (.*);
